@@ sv/wvc_pkg.sv @@
`timescale 1ns / 1ps
package wvc_pkg;

	// datapath widths
	localparam int XW    = 52;   // CORDIC position vector, signed
	localparam int UW    = 37;   // CORDIC velocity vector, signed
	localparam int RW    = 52;   // divider remainder
	localparam int DW    = 41;   // divider denominator
	localparam int QW    = 16;   // divider quotient
	localparam int GUARD = 16;

	localparam logic signed [16:0] PI_Q     = 17'sd25736;
	localparam logic signed [16:0] TWO_PI_Q = 17'sd51472;
	localparam logic [31:0]        INV_GAIN = 32'd2608131496;

	typedef enum logic [1:0] {
		KIND_TRANSLATE = 2'd0,
		KIND_ROTATE    = 2'd1,
		KIND_ZERO      = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_MAX_LINEAR_SPEED = 2'd0,
		REG_MAX_TURN_RATE    = 2'd1,
		REG_TIME_STEP        = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [UW-1:0] ux;
		logic signed [UW-1:0] uy;
	} cord_t;

	typedef struct packed {
		logic signed [15:0] dth;
		kind_t              kind;
		logic               flip;
	} side_t;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [DW-1:0] den;
		logic [QW-1:0] q;
		logic          sat;
	} div_t;

	typedef struct packed {
		logic [15:0]        vx;
		logic [15:0]        vy;
		logic signed [15:0] dth;
		kind_t              kind;
		logic [15:0]        steps;
	} dside_t;

endpackage

@@ sv/wvc_stage.sv @@
`timescale 1ns / 1ps
module wvc_stage #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic         valid_q;
	logic [W-1:0] data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= in_data;
		end
	end

endmodule

@@ sv/wvc_cordic_cell.sv @@
`timescale 1ns / 1ps
module wvc_cordic_cell import wvc_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  cord_t in_cord,
	input  side_t in_side,
	output logic  out_valid,
	input  logic  out_ready,
	output cord_t out_cord,
	output side_t out_side
);

	logic  valid_q;
	cord_t cord_q;
	side_t side_q;
	cord_t nxt;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_cord  = cord_q;
	assign out_side  = side_q;

	// rotate toward the x axis; y of zero takes the branch for negative y
	always_comb begin
		if (in_cord.y > 0) begin
			nxt.x  = in_cord.x + (in_cord.y >>> SHIFT);
			nxt.y  = in_cord.y - (in_cord.x >>> SHIFT);
			nxt.ux = in_cord.ux - (in_cord.uy >>> SHIFT);
			nxt.uy = in_cord.uy + (in_cord.ux >>> SHIFT);
		end else begin
			nxt.x  = in_cord.x - (in_cord.y >>> SHIFT);
			nxt.y  = in_cord.y + (in_cord.x >>> SHIFT);
			nxt.ux = in_cord.ux + (in_cord.uy >>> SHIFT);
			nxt.uy = in_cord.uy - (in_cord.ux >>> SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cord_q <= nxt;
			side_q <= in_side;
		end
	end

endmodule

@@ sv/wvc_div_cell.sv @@
`timescale 1ns / 1ps
module wvc_div_cell import wvc_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  div_t   in_div,
	input  dside_t in_side,
	output logic   out_valid,
	input  logic   out_ready,
	output div_t   out_div,
	output dside_t out_side
);

	localparam int SW = RW + QW + 1;

	logic          valid_q;
	div_t          div_q;
	dside_t        side_q;
	div_t          nxt;
	logic [SW-1:0] dsh;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_div   = div_q;
	assign out_side  = side_q;

	// one restoring step for quotient bit BIT
	always_comb begin
		dsh = SW'(in_div.den) << BIT;
		nxt = in_div;
		if (!in_div.sat && (SW'(in_div.rem) >= dsh)) begin
			nxt.rem = in_div.rem - dsh[RW-1:0];
			nxt.q   = in_div.q | (QW'(1) << BIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			div_q  <= nxt;
			side_q <= in_side;
		end
	end

endmodule

@@ sv/waypoint_velocity_command.sv @@
`timescale 1ns / 1ps
// Waypoint velocity command.
// Slave stream (s_*): one transaction carries a start pose and a target pose.
// Master stream (m_*): one transaction per input carries vel_x, vel_y,
// turn_rate and step_count in tdata; tuser holds the command kind
// (translate, rotate only, zero command).
// Config channel (cfg_*): cfg_index selects max_linear_speed (0),
// max_turn_rate (1) or time_step (2); other indexes are dropped. cfg_ready is
// always high. Write only while no transaction is in flight.
// Datapath: one cell per CORDIC micro-rotation plus two 16-cell restoring
// dividers (step count, then turn rate) and eight register stages.
// Throughput: one transaction per cycle while m_tready stays high;
// every cell holds one item.
// Each cell stalls only when its downstream neighbor is full, so a stalled
// receiver first fills the bubbles in the chain before s_tready drops.
// Reset clears all valid flags (chain empty) and loads the register
// defaults: speed 1.0 m/s, turn rate 1.0 rad/s, period 0.1 s.
module waypoint_velocity_command import wvc_pkg::*; #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// start_x, start_y, start_heading, target_x, target_y, target_heading
	input  logic [159:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// vel_x, vel_y, turn_rate, step_count
	output logic [63:0]  m_tdata,
	// command_kind
	output logic [1:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam int N = CORDIC_ITERATIONS;

	typedef struct packed {
		cord_t c;
		side_t s;
	} front_t;

	typedef struct packed {
		logic [XW-1:0] xm;
		logic [UW-1:0] vxm;
		logic [UW-1:0] vym;
		logic          vxn;
		logic          vyn;
		side_t         s;
	} p1_t;

	typedef struct packed {
		logic [63:0]   xlo;
		logic [51:0]   xhi;
		logic [63:0]   vxlo;
		logic [UW-1:0] vxhi;
		logic [63:0]   vylo;
		logic [UW-1:0] vyhi;
		logic          vxn;
		logic          vyn;
		logic [39:0]   dl;
		logic [31:0]   dr;
		side_t         s;
	} p2_t;

	typedef struct packed {
		logic [RW-1:0] distance;
		logic [15:0]   vx;
		logic [15:0]   vy;
		logic [39:0]   dl;
		logic [31:0]   dr;
		side_t         s;
	} p3_t;

	typedef struct packed {
		div_t   d;
		dside_t s;
	} dv_t;

	typedef struct packed {
		dside_t      s;
		logic [31:0] den2;
	} p5_t;

	// configuration registers
	logic [15:0] mls_q, mtr_q, ts_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mls_q <= 16'd256;
			mtr_q <= 16'd256;
			ts_q  <= 16'd6554;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_LINEAR_SPEED: mls_q <= cfg_data;
				REG_MAX_TURN_RATE:    mtr_q <= cfg_data;
				REG_TIME_STEP:        ts_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: deltas, heading wrap, fold into the right half plane
	logic signed [31:0] sx, sy, tx, ty;
	logic signed [15:0] sh, th;
	logic signed [32:0] dx, dy;
	logic signed [16:0] dth_raw, dth_w;
	logic [32:0]        adx, ady;
	logic [48:0]        ay49;
	logic               flip, yneg;
	front_t             f_in, f_out;
	logic               f_valid, f_ready;

	always_comb begin
		sx = s_tdata[31:0];
		sy = s_tdata[63:32];
		sh = s_tdata[79:64];
		tx = s_tdata[111:80];
		ty = s_tdata[143:112];
		th = s_tdata[159:144];
		dx = 33'(tx) - 33'(sx);
		dy = 33'(ty) - 33'(sy);
		dth_raw = 17'(th) - 17'(sh);
		if (dth_raw > PI_Q) begin
			dth_w = dth_raw - TWO_PI_Q;
		end else if (dth_raw <= -PI_Q) begin
			dth_w = dth_raw + TWO_PI_Q;
		end else begin
			dth_w = dth_raw;
		end
		flip = dx < 0;
		adx  = flip ? 33'(-dx) : 33'(dx);
		ady  = (dy < 0) ? 33'(-dy) : 33'(dy);
		yneg = (dy < 0) != flip;
		ay49 = {ady, 16'b0};
		f_in.c.x  = $signed(XW'({adx, 16'b0}));
		f_in.c.y  = yneg ? -$signed(XW'(ay49)) : $signed(XW'(ay49));
		f_in.c.ux = $signed(UW'({mls_q, 16'b0}));
		f_in.c.uy = '0;
		f_in.s.dth  = dth_w[15:0];
		f_in.s.flip = flip;
		if (dx != 0 || dy != 0) begin
			f_in.s.kind = KIND_TRANSLATE;
		end else if (dth_w != 0) begin
			f_in.s.kind = KIND_ROTATE;
		end else begin
			f_in.s.kind = KIND_ZERO;
		end
	end

	wvc_stage #(.W($bits(front_t))) u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(f_in),
		.out_valid(f_valid), .out_ready(f_ready), .out_data(f_out)
	);

	// CORDIC chain: one micro-rotation per cell
	cord_t cc [0:N];
	side_t cs [0:N];
	logic  cv [0:N];
	logic  cr [0:N];

	assign cc[0]   = f_out.c;
	assign cs[0]   = f_out.s;
	assign cv[0]   = f_valid;
	assign f_ready = cr[0];

	for (genvar i = 0; i < N; i++) begin : g_cordic
		wvc_cordic_cell #(.SHIFT(i)) u_cell (
			.clk, .arst_n,
			.in_valid(cv[i]), .in_ready(cr[i]), .in_cord(cc[i]), .in_side(cs[i]),
			.out_valid(cv[i+1]), .out_ready(cr[i+1]),
			.out_cord(cc[i+1]), .out_side(cs[i+1])
		);
	end

	// P1: undo the fold, split into magnitude and sign
	p1_t               p1_in, p1_out;
	logic              p1_valid, p1_ready;
	logic signed [UW-1:0] uxf, uyf;

	always_comb begin
		uxf = cs[N].flip ? -cc[N].ux : cc[N].ux;
		uyf = cs[N].flip ? -cc[N].uy : cc[N].uy;
		p1_in.xm  = cc[N].x;
		p1_in.vxn = uxf[UW-1];
		p1_in.vyn = uyf[UW-1];
		p1_in.vxm = uxf[UW-1] ? UW'(-uxf) : UW'(uxf);
		p1_in.vym = uyf[UW-1] ? UW'(-uyf) : UW'(uyf);
		p1_in.s   = cs[N];
	end

	wvc_stage #(.W($bits(p1_t))) u_p1 (
		.clk, .arst_n,
		.in_valid(cv[N]), .in_ready(cr[N]), .in_data(p1_in),
		.out_valid(p1_valid), .out_ready(p1_ready), .out_data(p1_out)
	);

	// P2: gain correction partial products, period products
	p2_t  p2_in, p2_out;
	logic p2_valid, p2_ready;

	always_comb begin
		p2_in.xlo  = 64'(p1_out.xm[31:0]) * 64'(INV_GAIN);
		p2_in.xhi  = 52'(p1_out.xm[XW-1:32]) * 52'(INV_GAIN);
		p2_in.vxlo = 64'(p1_out.vxm[31:0]) * 64'(INV_GAIN);
		p2_in.vxhi = UW'(p1_out.vxm[UW-1:32]) * UW'(INV_GAIN);
		p2_in.vylo = 64'(p1_out.vym[31:0]) * 64'(INV_GAIN);
		p2_in.vyhi = UW'(p1_out.vym[UW-1:32]) * UW'(INV_GAIN);
		p2_in.vxn  = p1_out.vxn;
		p2_in.vyn  = p1_out.vyn;
		p2_in.dl   = {(32'(mls_q) * 32'(ts_q)), 8'b0};
		p2_in.dr   = 32'(mtr_q) * 32'(ts_q);
		p2_in.s    = p1_out.s;
	end

	wvc_stage #(.W($bits(p2_t))) u_p2 (
		.clk, .arst_n,
		.in_valid(p1_valid), .in_ready(p1_ready), .in_data(p2_in),
		.out_valid(p2_valid), .out_ready(p2_ready), .out_data(p2_out)
	);

	// P3: distance, velocity rounding and saturation
	function automatic logic [15:0] scale_vel(input logic [UW-1:0] hi,
			input logic [63:0] lo, input logic neg);
		logic [UW:0] m;
		logic [UW:0] r;
		logic [15:0] res;
		m = (UW+1)'(hi) + (UW+1)'(lo[63:32]);
		r = (m + (UW+1)'(1 << (GUARD - 1))) >> GUARD;
		if (neg) begin
			res = (r > (UW+1)'(32768)) ? 16'h8000 : 16'(-r);
		end else begin
			res = (r > (UW+1)'(32767)) ? 16'h7FFF : r[15:0];
		end
		return res;
	endfunction

	p3_t  p3_in, p3_out;
	logic p3_valid, p3_ready;

	always_comb begin
		p3_in.distance = RW'(p2_out.xhi) + RW'(p2_out.xlo[63:32]);
		p3_in.vx       = scale_vel(p2_out.vxhi, p2_out.vxlo, p2_out.vxn);
		p3_in.vy       = scale_vel(p2_out.vyhi, p2_out.vylo, p2_out.vyn);
		p3_in.dl       = p2_out.dl;
		p3_in.dr       = p2_out.dr;
		p3_in.s        = p2_out.s;
	end

	wvc_stage #(.W($bits(p3_t))) u_p3 (
		.clk, .arst_n,
		.in_valid(p2_valid), .in_ready(p2_ready), .in_data(p3_in),
		.out_valid(p3_valid), .out_ready(p3_ready), .out_data(p3_out)
	);

	// P4: ceiling-division operands for the step count
	dv_t           p4_in;
	logic [15:0]   adth3;
	logic [DW-1:0] den4;
	logic [RW-1:0] num4;

	always_comb begin
		adth3 = (p3_out.s.dth < 0) ? 16'(-p3_out.s.dth) : 16'(p3_out.s.dth);
		if (p3_out.s.kind == KIND_TRANSLATE) begin
			den4 = DW'(p3_out.dl);
			num4 = p3_out.distance + RW'(den4) - RW'(1);
		end else begin
			den4 = DW'(p3_out.dr);
			num4 = (RW'(adth3) << 11) + RW'(den4) - RW'(1);
		end
		p4_in.d.rem = num4;
		p4_in.d.den = den4;
		p4_in.d.q   = '0;
		p4_in.d.sat = (den4 == '0) || ({5'b0, num4} >= {den4, 16'b0});
		p4_in.s.vx    = p3_out.vx;
		p4_in.s.vy    = p3_out.vy;
		p4_in.s.dth   = p3_out.s.dth;
		p4_in.s.kind  = p3_out.s.kind;
		p4_in.s.steps = '0;
	end

	div_t   sd [0:QW];
	dside_t ss [0:QW];
	logic   sv [0:QW];
	logic   sr [0:QW];

	wvc_stage #(.W($bits(dv_t))) u_p4 (
		.clk, .arst_n,
		.in_valid(p3_valid), .in_ready(p3_ready), .in_data(p4_in),
		.out_valid(sv[0]), .out_ready(sr[0]), .out_data({sd[0], ss[0]})
	);

	// step count divider, most significant quotient bit first
	for (genvar i = 0; i < QW; i++) begin : g_sdiv
		wvc_div_cell #(.BIT(QW - 1 - i)) u_cell (
			.clk, .arst_n,
			.in_valid(sv[i]), .in_ready(sr[i]), .in_div(sd[i]), .in_side(ss[i]),
			.out_valid(sv[i+1]), .out_ready(sr[i+1]),
			.out_div(sd[i+1]), .out_side(ss[i+1])
		);
	end

	// P5: final step count, denominator for the turn rate
	p5_t         p5_in, p5_out;
	logic        p5_valid, p5_ready;
	logic [15:0] steps5;

	always_comb begin
		if (ss[QW].kind == KIND_ZERO) begin
			steps5 = 16'd1;
		end else if (sd[QW].sat) begin
			steps5 = 16'hFFFF;
		end else begin
			steps5 = sd[QW].q;
		end
		p5_in.s       = ss[QW];
		p5_in.s.steps = steps5;
		p5_in.den2    = 32'(steps5) * 32'(ts_q);
	end

	wvc_stage #(.W($bits(p5_t))) u_p5 (
		.clk, .arst_n,
		.in_valid(sv[QW]), .in_ready(sr[QW]), .in_data(p5_in),
		.out_valid(p5_valid), .out_ready(p5_ready), .out_data(p5_out)
	);

	// P6: rounded-division operands for the turn rate
	dv_t           p6_in;
	logic [15:0]   adth6;
	logic [RW-1:0] num6;
	logic [DW-1:0] den6;

	always_comb begin
		adth6 = (p5_out.s.dth < 0) ? 16'(-p5_out.s.dth) : 16'(p5_out.s.dth);
		den6  = DW'(p5_out.den2);
		num6  = (RW'(adth6) << 11) + RW'(p5_out.den2 >> 1);
		p6_in.d.rem = num6;
		p6_in.d.den = den6;
		p6_in.d.q   = '0;
		p6_in.d.sat = {5'b0, num6} >= {den6, 16'b0};
		p6_in.s     = p5_out.s;
	end

	div_t   td [0:QW];
	dside_t ts [0:QW];
	logic   tv [0:QW];
	logic   tr [0:QW];

	wvc_stage #(.W($bits(dv_t))) u_p6 (
		.clk, .arst_n,
		.in_valid(p5_valid), .in_ready(p5_ready), .in_data(p6_in),
		.out_valid(tv[0]), .out_ready(tr[0]), .out_data({td[0], ts[0]})
	);

	// turn rate divider
	for (genvar i = 0; i < QW; i++) begin : g_tdiv
		wvc_div_cell #(.BIT(QW - 1 - i)) u_cell (
			.clk, .arst_n,
			.in_valid(tv[i]), .in_ready(tr[i]), .in_div(td[i]), .in_side(ts[i]),
			.out_valid(tv[i+1]), .out_ready(tr[i+1]),
			.out_div(td[i+1]), .out_side(ts[i+1])
		);
	end

	// Output: turn rate select and saturation, result register
	logic [15:0] w, vx_o, vy_o;
	logic [65:0] o_in, o_out;
	dside_t      fs;
	div_t        fd;

	always_comb begin
		fs   = ts[QW];
		fd   = td[QW];
		w    = '0;
		vx_o = '0;
		vy_o = '0;
		case (fs.kind)
			KIND_TRANSLATE: begin
				vx_o = fs.vx;
				vy_o = fs.vy;
				if (fs.dth == 0) begin
					w = '0;
				end else if (fd.den == '0) begin
					w = (fs.dth > 0) ? 16'h7FFF : 16'h8000;
				end else if (fs.dth > 0) begin
					w = (fd.sat || fd.q > 16'd32767) ? 16'h7FFF : fd.q;
				end else begin
					w = (fd.sat || fd.q > 16'd32768) ? 16'h8000 : 16'(-fd.q);
				end
			end
			KIND_ROTATE: begin
				if (fs.dth > 0) begin
					w = (mtr_q > 16'd32767) ? 16'h7FFF : mtr_q;
				end else begin
					w = (mtr_q > 16'd32768) ? 16'h8000 : 16'(-mtr_q);
				end
			end
			default: ;
		endcase
		o_in = {fs.kind, fs.steps, w, vy_o, vx_o};
	end

	wvc_stage #(.W(66)) u_out (
		.clk, .arst_n,
		.in_valid(tv[QW]), .in_ready(tr[QW]), .in_data(o_in),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(o_out)
	);

	assign m_tdata = o_out[63:0];
	assign m_tuser = o_out[65:64];

endmodule

@@ sim/waypoint_velocity_command_tb.sv @@
`timescale 1ns / 1ps
module waypoint_velocity_command_tb import wvc_pkg::*;;

	typedef struct {
		logic [15:0] vx;
		logic [15:0] vy;
		logic [15:0] w;
		logic [15:0] steps;
		logic [1:0]  kind;
	} command_t;

	// pending commands, oldest first
	class command_scoreboard;
		command_t pending[$];
		int       mismatches;

		function void note_accepted(command_t c);
			pending = {pending, c};
		endfunction

		function void check_result(logic [63:0] data, logic [1:0] user);
			command_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h kind %0d", data, user);
				return;
			end
			e = pending.pop_front();
			if (data !== {e.steps, e.w, e.vy, e.vx} || user !== e.kind) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp vx %h vy %h w %h n %h k %0d, got %h k %0d",
						e.vx, e.vy, e.w, e.steps, e.kind, data, user);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [15:0]  cfg_data;

	localparam int LATENCY = 16 + 40;
	localparam longint CYCLE_LIMIT = 400000;

	command_scoreboard sb;
	// model copy of the registers
	logic [15:0] lin_speed, turn_max, period;
	longint      cycles;
	bit          holdoff;   // long receiver stall requested
	bit          no_idle;   // quiet stretch without random gaps

	waypoint_velocity_command u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned mul_gain(longint unsigned a);
		longint unsigned hi, lo, c;
		c  = 64'(INV_GAIN);
		hi = a >> 32;
		lo = a & 64'hFFFF_FFFF;
		return hi * c + ((lo * c) >> 32);
	endfunction

	function automatic longint unsigned ceil_steps(longint unsigned num, longint unsigned den);
		longint unsigned q;
		if (den == 0) return 65535;
		q = (num + den - 1) / den;
		return q > 65535 ? 65535 : q;
	endfunction

	function automatic logic [15:0] round_velocity(longint v);
		longint unsigned m;
		m = v < 0 ? longint'(-v) : v;
		m = (mul_gain(m) + (64'd1 << (GUARD - 1))) >> GUARD;
		if (v < 0) begin
			if (m > 32768) m = 32768;
			return 16'(-m);
		end
		if (m > 32767) m = 32767;
		return 16'(m);
	endfunction

	// expected command for one pose pair
	function automatic command_t plan_command(logic [159:0] d);
		command_t c;
		longint dx, dy, dth, x, y, ux, uy, nx, ny, nux, nuy;
		longint unsigned distance, den, num, q, ax;
		bit flip;
		dx  = longint'($signed(d[111:80])) - longint'($signed(d[31:0]));
		dy  = longint'($signed(d[143:112])) - longint'($signed(d[63:32]));
		dth = longint'($signed(d[159:144])) - longint'($signed(d[79:64]));
		c.vx = 0; c.vy = 0; c.w = 0; c.steps = 1; c.kind = KIND_ZERO;
		while (dth > 25736) dth -= 51472;
		while (dth <= -25736) dth += 51472;
		if (dx != 0 || dy != 0) begin
			flip = dx < 0;
			x = (flip ? -dx : dx) <<< GUARD;
			y = (dy < 0 ? -dy : dy) <<< GUARD;
			if ((dy < 0) != flip) y = -y;
			ux = longint'(lin_speed) <<< GUARD;
			uy = 0;
			for (int i = 0; i < 16; i++) begin
				if (y > 0) begin
					nx = x + shr_floor(y, i); ny = y - shr_floor(x, i);
					nux = ux - shr_floor(uy, i); nuy = uy + shr_floor(ux, i);
				end else begin
					nx = x - shr_floor(y, i); ny = y + shr_floor(x, i);
					nux = ux + shr_floor(uy, i); nuy = uy - shr_floor(ux, i);
				end
				x = nx; y = ny; ux = nux; uy = nuy;
			end
			if (flip) begin
				ux = -ux; uy = -uy;
			end
			ax = x;
			distance = mul_gain(ax);
			c.steps = ceil_steps(distance, (64'(lin_speed) * 64'(period)) << 8);
			c.vx = round_velocity(ux);
			c.vy = round_velocity(uy);
			den = 64'(c.steps) * 64'(period);
			if (dth == 0) c.w = 0;
			else if (den == 0) c.w = dth > 0 ? 16'h7FFF : 16'h8000;
			else begin
				num = longint'(dth < 0 ? -dth : dth) << 11;
				q = (num + den / 2) / den;
				if (dth > 0) c.w = q > 32767 ? 16'd32767 : 16'(q);
				else c.w = 16'(-(q > 32768 ? 64'd32768 : q));
			end
			c.kind = KIND_TRANSLATE;
		end else if (dth != 0) begin
			num = longint'(dth < 0 ? -dth : dth) << 11;
			c.steps = ceil_steps(num, 64'(turn_max) * 64'(period));
			if (dth > 0) c.w = turn_max > 32767 ? 16'd32767 : turn_max;
			else c.w = 16'(-(turn_max > 32768 ? 32'd32768 : 32'(turn_max)));
			c.kind = KIND_ROTATE;
		end
		return c;
	endfunction

	task automatic write_register(reg_idx_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MAX_LINEAR_SPEED: lin_speed = value;
			REG_MAX_TURN_RATE:    turn_max = value;
			default:              period = value;
		endcase
		@(posedge clk);
	endtask

	task automatic send_pose(logic [159:0] d);
		if (!no_idle) begin
			while ($urandom_range(99) < 9) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_accepted(plan_command(d));
	endtask

	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_pos(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(2000) - 1000;
			default: return 32'($signed($urandom_range(400000)) - 200000) <<< $urandom_range(12);
		endcase
	endfunction

	function automatic logic [15:0] rand_heading();
		return 16'($urandom_range(51472) - 25736);
	endfunction

	// random pose pair: small, wide or full-range moves, some rotate-only and zero cases
	function automatic logic [159:0] rand_pose();
		logic [31:0] sx, sy, tx, ty;
		logic [15:0] sh, th;
		int r, m;
		r = $urandom_range(99);
		m = $urandom_range(2);
		sx = rand_pos(m); sy = rand_pos(m); sh = rand_heading();
		tx = rand_pos(m); ty = rand_pos(m); th = rand_heading();
		if (r < 15) begin
			tx = sx; ty = sy;
		end else if (r < 20) begin
			tx = sx; ty = sy; th = sh;
		end else if (r < 25) begin
			tx = sx;
		end else if (r < 30) begin
			ty = sy;
		end else if (r < 35) begin
			th = sh;
		end
		return {th, ty, tx, sh, sy, sx};
	endfunction

	// receiver: random stalls, plus one long hold-off
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holdoff) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				holdoff = 0;
			end
			m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 9);
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] speeds[5];
		logic [15:0] rates[5];
		logic [15:0] periods[5];
		logic [31:0] ext[4];
		sb = new();
		holdoff = 0;
		no_idle = 0;
		s_tvalid <= 1'b0; s_tdata <= '0;
		cfg_valid <= 1'b0; cfg_index <= REG_MAX_LINEAR_SPEED; cfg_data <= '0;
		lin_speed = 256; turn_max = 256; period = 6554;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes at reset settings
		ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
		foreach (ext[i])
			send_pose({16'sd25736, ext[3 - i], ext[i], -16'sd25736, ext[i], ext[3 - i]});
		send_pose({16'd0, 32'd5, 32'd7, 16'd0, 32'd5, 32'd7});            // zero command
		send_pose({16'sd100, 32'd5, 32'd7, -16'sd100, 32'd5, 32'd7});     // rotate, positive
		send_pose({-16'sd100, 32'd5, 32'd7, 16'sd100, 32'd5, 32'd7});     // rotate, negative
		send_pose({-16'sd25736, 32'd0, 32'd0, 16'sd25736, 32'd0, 32'd0}); // wrap edge
		send_pose({16'sd25736, 32'd0, 32'd0, -16'sd25736, 32'd0, 32'd0});
		send_pose({16'sd0, 32'd0, 32'hFFFF_0000, 16'sd0, 32'd0, 32'd0});  // tie: dy zero, dx<0
		send_pose({16'sd0, 32'd65536, 32'd0, 16'sd0, 32'd0, 32'd0});      // straight up
		send_pose({16'sd0, 32'd1, 32'd1, 16'sd1, 32'd0, 32'd0});          // tiny move
		send_pose({16'sd25736, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -16'sd25736,
			32'h8000_0000, 32'h8000_0000});                                   // saturating count
		drain_pipeline();

		speeds  = '{16'd1, 16'd65535, 16'd256, 16'd4096, 16'd37};
		rates   = '{16'd65535, 16'd1, 16'd32768, 16'd256, 16'd900};
		periods = '{16'd1, 16'd65535, 16'd6554, 16'd100, 16'd30000};
		for (int p = 0; p < 5; p++) begin
			write_register(REG_MAX_LINEAR_SPEED, speeds[p]);
			write_register(REG_MAX_TURN_RATE, rates[p]);
			write_register(REG_TIME_STEP, periods[p]);
			if (p == 2) holdoff = 1;   // back up the pipeline once
			no_idle = (p == 3);
			for (int n = 0; n < 390; n++) send_pose(rand_pose());
			drain_pipeline();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

@@ files.f @@
sv/wvc_pkg.sv
sv/wvc_stage.sv
sv/wvc_cordic_cell.sv
sv/wvc_div_cell.sv
sv/waypoint_velocity_command.sv
sim/waypoint_velocity_command_tb.sv
